/* hw/rtl/breakable_damped_spring_force_defines.svh */
// Assertion macros shared by the spring force RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BREAKABLE_DAMPED_SPRING_FORCE_DEFINES_SVH
`define BREAKABLE_DAMPED_SPRING_FORCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bdsf_pkg.sv */
// Types, widths and helper functions for the breakable spring force block.
// No dependencies; used by the interfaces and the top level.
package bdsf_pkg;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned DIFF_W     = 33;
  localparam int unsigned DRAG_M_W   = 49;
  localparam int unsigned DIST_W     = 34;
  localparam int unsigned SQ_REM_W   = 68;
  localparam int unsigned SQRT_STEPS = 34;
  localparam int unsigned DEN_W      = 50;
  localparam int unsigned DIV_STEPS  = 50;
  localparam int unsigned FORCE_W    = 48;
  localparam int unsigned LIMIT_W    = 47;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_DRAG  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 4'd1;

  localparam logic [31:0]        DRAG_RESET  = 32'd655360;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 47'd6553600000;

  // Context that travels with an item down the arithmetic pipeline.
  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [DIFF_W-1:0]   adx;
    logic [DIFF_W-1:0]   ady;
    logic                sdx;
    logic                sdy;
    logic [DRAG_M_W-1:0] mdrx;
    logic [DRAG_M_W-1:0] mdry;
    logic                sdvx;
    logic                sdvy;
    logic [31:0]         stiff;
    logic [31:0]         rest;
    logic [DIST_W-1:0]   root;
    logic                coinc;
    logic                sdiff;
  } ctx_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [FORCE_W-1:0] fx;
    logic [FORCE_W-1:0] fy;
    logic               coinc;
  } res_t;

  typedef struct packed {
    logic [FORCE_W-1:0] force_x;
    logic [FORCE_W-1:0] force_y;
    logic               was_active;
    logic               just_broke;
    logic               coincident_ends;
  } out_t;

  function automatic logic [FORCE_W-1:0] sat48(input logic [51:0] v);
    logic [FORCE_W-1:0] r;
    if (!v[51] && (v[50:47] != 4'b0000)) begin
      r = {1'b0, {(FORCE_W-1){1'b1}}};
    end else if (v[51] && (v[50:47] != 4'b1111)) begin
      r = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      r = v[FORCE_W-1:0];
    end
    return r;
  endfunction

  // Square of a 48-bit value from its three 24-bit partial products.
  function automatic logic [95:0] sq_combine(input logic [47:0] hh, input logic [47:0] hl,
                                             input logic [47:0] ll);
    return (96'(hh) << 48) + (96'(hl) << 25) + 96'(ll);
  endfunction

endpackage

/* hw/rtl/bdsf_if.sv */
// Handshake channels of the spring force block: spring items, results, config.
// Depends on bdsf_pkg.
interface bdsf_in_if;
  logic                    valid;
  logic                    ready;
  logic [9:0]              spring_index;
  logic signed [31:0]      end_a_x;
  logic signed [31:0]      end_a_y;
  logic signed [31:0]      end_b_x;
  logic signed [31:0]      end_b_y;
  logic signed [31:0]      end_a_vx;
  logic signed [31:0]      end_a_vy;
  logic signed [31:0]      end_b_vx;
  logic signed [31:0]      end_b_vy;
  logic [31:0]             stiffness;
  logic [31:0]             rest_length;

  modport source (output valid, spring_index, end_a_x, end_a_y, end_b_x, end_b_y,
                  end_a_vx, end_a_vy, end_b_vx, end_b_vy, stiffness, rest_length,
                  input ready);
  modport sink (input valid, spring_index, end_a_x, end_a_y, end_b_x, end_b_y,
                end_a_vx, end_a_vy, end_b_vx, end_b_vy, stiffness, rest_length,
                output ready);
endinterface

interface bdsf_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [47:0]      force_x;
  logic signed [47:0]      force_y;
  logic                    was_active;
  logic                    just_broke;
  logic                    coincident_ends;

  modport source (output valid, force_x, force_y, was_active, just_broke, coincident_ends,
                  input ready);
  modport sink (input valid, force_x, force_y, was_active, just_broke, coincident_ends,
                output ready);
endinterface

interface bdsf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bdsf_pkg::CFG_IDX_W-1:0]     index;
  logic [bdsf_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/breakable_damped_spring_force.sv */
// Breakable damped 2-D spring force: pipelined evaluator with a broken-flag memory.
// Depends on bdsf_pkg, the interfaces in bdsf_if.sv and the assertion macro header.
//
// Usage:
//   in_i carries one spring per beat (index, end positions and velocities, stiffness,
//   rest length). out_o returns one beat per item, in order: the force on end A,
//   was_active, just_broke and coincident_ends. cfg_i writes drag_coefficient
//   (index 0) and force_limit (index 1); it is always ready and should be used idle.
//   Throughput is one item per cycle while the skid entry is free. The pipeline depth
//   comes from the 34-step square root and the 50-step quotient pipelines, one result
//   bit per stage.
//   The broken flags sit in a one-bit memory read one stage before the output and
//   written as the item leaves, with a bypass for an item of the same spring that
//   follows directly.
//   After reset the flag memory is cleared, one entry per cycle, through all SPRING_COUNT
//   entries; in_i.ready stays low during that pass. The config registers take their
//   default values at reset.
//   A two-entry output stage lets the pipeline keep taking items while one result
//   waits; when the receiver stalls longer, the pipeline and in_i.ready hold.
`include "breakable_damped_spring_force_defines.svh"

module breakable_damped_spring_force #(
  parameter int unsigned SPRING_COUNT = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bdsf_in_if.sink           in_i,
  bdsf_out_if.source        out_o,
  bdsf_cfg_if.sink          cfg_i
);

  localparam int unsigned AW = (SPRING_COUNT > 1) ? $clog2(SPRING_COUNT) : 1;
  localparam int unsigned IW = (AW > bdsf_pkg::IDX_W) ? AW : bdsf_pkg::IDX_W;
  localparam logic [16:0] COUNT_L = 17'(SPRING_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SPRING_COUNT - 1);
  localparam int unsigned SQS = bdsf_pkg::SQRT_STEPS;
  localparam int unsigned DVS = bdsf_pkg::DIV_STEPS;

  // ---------------------------------------------------------------- config
  logic [31:0]                    drag_q;
  logic [bdsf_pkg::LIMIT_W-1:0]   limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q  <= bdsf_pkg::DRAG_RESET;
      limit_q <= bdsf_pkg::LIMIT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bdsf_pkg::REG_DRAG:  drag_q  <= cfg_i.data[31:0];
        bdsf_pkg::REG_LIMIT: limit_q <= cfg_i.data[bdsf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic skid_vld_q;
  logic out_vld_q;
  logic clr_done_q;
  logic [AW-1:0] clr_cnt_q;
  logic en;

  // The whole pipeline advances unless the skid entry is occupied.
  assign en = !skid_vld_q;
  assign in_i.ready = en && clr_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == LAST_ADDR) begin
        clr_done_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: differences
  logic                        s1_vld_q;
  logic [bdsf_pkg::IDX_W-1:0]  s1_idx_q;
  logic [32:0]                 s1_dx_q, s1_dy_q, s1_dvx_q, s1_dvy_q;
  logic [31:0]                 s1_stiff_q, s1_rest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_i.valid && clr_done_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_idx_q   <= in_i.spring_index;
      s1_dx_q    <= {in_i.end_a_x[31], in_i.end_a_x} - {in_i.end_b_x[31], in_i.end_b_x};
      s1_dy_q    <= {in_i.end_a_y[31], in_i.end_a_y} - {in_i.end_b_y[31], in_i.end_b_y};
      s1_dvx_q   <= {in_i.end_a_vx[31], in_i.end_a_vx} - {in_i.end_b_vx[31], in_i.end_b_vx};
      s1_dvy_q   <= {in_i.end_a_vy[31], in_i.end_a_vy} - {in_i.end_b_vy[31], in_i.end_b_vy};
      s1_stiff_q <= in_i.stiffness;
      s1_rest_q  <= in_i.rest_length;
    end
  end

  // ---------------------------------------------------------------- stage 2: squares, drag
  logic [32:0]       s1_adx, s1_ady, s1_advx, s1_advy;
  logic              s2_vld_q;
  bdsf_pkg::ctx_t    s2_ctx_d;
  bdsf_pkg::ctx_t    s2_ctx_q;
  logic [65:0]       s2_sqx_q, s2_sqy_q;
  logic [64:0]       s2_prx_q, s2_pry_q;

  assign s1_adx  = s1_dx_q[32]  ? (33'd0 - s1_dx_q)  : s1_dx_q;
  assign s1_ady  = s1_dy_q[32]  ? (33'd0 - s1_dy_q)  : s1_dy_q;
  assign s1_advx = s1_dvx_q[32] ? (33'd0 - s1_dvx_q) : s1_dvx_q;
  assign s1_advy = s1_dvy_q[32] ? (33'd0 - s1_dvy_q) : s1_dvy_q;

  always_comb begin
    s2_ctx_d       = '0;
    s2_ctx_d.idx   = s1_idx_q;
    s2_ctx_d.adx   = s1_adx;
    s2_ctx_d.ady   = s1_ady;
    s2_ctx_d.sdx   = s1_dx_q[32];
    s2_ctx_d.sdy   = s1_dy_q[32];
    s2_ctx_d.sdvx  = s1_dvx_q[32];
    s2_ctx_d.sdvy  = s1_dvy_q[32];
    s2_ctx_d.stiff = s1_stiff_q;
    s2_ctx_d.rest  = s1_rest_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ctx_q <= s2_ctx_d;
      s2_sqx_q <= 66'(s1_adx) * 66'(s1_adx);
      s2_sqy_q <= 66'(s1_ady) * 66'(s1_ady);
      s2_prx_q <= 65'(drag_q) * 65'(s1_advx);
      s2_pry_q <= 65'(drag_q) * 65'(s1_advy);
    end
  end

  // ---------------------------------------------------------------- square root
  logic [bdsf_pkg::SQ_REM_W-1:0] sq_rem_q  [SQS+1];
  logic [bdsf_pkg::DIST_W-1:0]   sq_root_q [SQS+1];
  bdsf_pkg::ctx_t                sq_ctx_q  [SQS+1];
  bdsf_pkg::ctx_t                sq_ctx_d;
  logic [SQS:0]                  sq_vld_q;

  always_comb begin
    sq_ctx_d      = s2_ctx_q;
    sq_ctx_d.mdrx = s2_prx_q[64:16];
    sq_ctx_d.mdry = s2_pry_q[64:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else if (en) begin
      sq_vld_q <= {sq_vld_q[SQS-1:0], s2_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= 68'(s2_sqx_q) + 68'(s2_sqy_q);
      sq_root_q[0] <= '0;
      sq_ctx_q[0]  <= sq_ctx_d;
    end
  end

  // One root bit per stage; the remainder holds the value minus the root squared.
  for (genvar j = 0; j < SQS; j++) begin : g_sqrt
    localparam int unsigned B = SQS - 1 - j;
    logic [bdsf_pkg::SQ_REM_W-1:0] trial;
    logic                          take;

    assign trial = (68'(sq_root_q[j]) << (B + 1)) + (68'd1 << (2 * B));
    assign take  = sq_rem_q[j] >= trial;

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[j+1]  <= take ? (sq_rem_q[j] - trial) : sq_rem_q[j];
        sq_root_q[j+1] <= take ? (sq_root_q[j] | (34'd1 << B)) : sq_root_q[j];
        sq_ctx_q[j+1]  <= sq_ctx_q[j];
      end
    end
  end

  // ---------------------------------------------------------------- stage 4: stiffness term
  logic [34:0]     s3_diff;
  logic [33:0]     s3_adiff;
  logic            s4_vld_q;
  bdsf_pkg::ctx_t  s4_ctx_d;
  bdsf_pkg::ctx_t  s4_ctx_q;
  logic [65:0]     s4_kd_q;

  assign s3_diff  = 35'(sq_ctx_q[SQS].rest) - 35'(sq_root_q[SQS]);
  assign s3_adiff = s3_diff[34] ? 34'(35'd0 - s3_diff) : s3_diff[33:0];

  always_comb begin
    s4_ctx_d       = sq_ctx_q[SQS];
    s4_ctx_d.root  = sq_root_q[SQS];
    s4_ctx_d.coinc = (sq_root_q[SQS] == '0);
    s4_ctx_d.sdiff = s3_diff[34];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= sq_vld_q[SQS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_ctx_q <= s4_ctx_d;
      s4_kd_q  <= 66'(sq_ctx_q[SQS].stiff) * 66'(s3_adiff);
    end
  end

  // ---------------------------------------------------------------- stage 5: split products
  logic            s5_vld_q;
  bdsf_pkg::ctx_t  s5_ctx_q;
  logic [64:0]     s5_plx_q, s5_ply_q;
  logic [66:0]     s5_phx_q, s5_phy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_ctx_q <= s4_ctx_q;
      s5_plx_q <= 65'(s4_kd_q[31:0])  * 65'(s4_ctx_q.adx);
      s5_ply_q <= 65'(s4_kd_q[31:0])  * 65'(s4_ctx_q.ady);
      s5_phx_q <= 67'(s4_kd_q[65:32]) * 67'(s4_ctx_q.adx);
      s5_phy_q <= 67'(s4_kd_q[65:32]) * 67'(s4_ctx_q.ady);
    end
  end

  // ---------------------------------------------------------------- division
  logic [98:0]                   s5_numx, s5_numy;
  logic [bdsf_pkg::DEN_W-1:0]    dvx_rem_q [DVS+1];
  logic [bdsf_pkg::DEN_W-1:0]    dvy_rem_q [DVS+1];
  logic [bdsf_pkg::DEN_W-1:0]    dvx_quo_q [DVS+1];
  logic [bdsf_pkg::DEN_W-1:0]    dvy_quo_q [DVS+1];
  logic [bdsf_pkg::DEN_W-1:0]    dvx_num_q [DVS+1];
  logic [bdsf_pkg::DEN_W-1:0]    dvy_num_q [DVS+1];
  bdsf_pkg::ctx_t                dv_ctx_q  [DVS+1];
  logic [DVS:0]                  dv_vld_q;

  assign s5_numx = 99'(s5_plx_q) + (99'(s5_phx_q) << 32);
  assign s5_numy = 99'(s5_ply_q) + (99'(s5_phy_q) << 32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (en) begin
      dv_vld_q <= {dv_vld_q[DVS-1:0], s5_vld_q};
    end
  end

  // The quotient stays below 2^50, so the top numerator bits start below the divisor.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dvx_rem_q[0] <= {1'b0, s5_numx[98:50]};
      dvy_rem_q[0] <= {1'b0, s5_numy[98:50]};
      dvx_num_q[0] <= s5_numx[49:0];
      dvy_num_q[0] <= s5_numy[49:0];
      dvx_quo_q[0] <= '0;
      dvy_quo_q[0] <= '0;
      dv_ctx_q[0]  <= s5_ctx_q;
    end
  end

  for (genvar j = 0; j < DVS; j++) begin : g_div
    localparam int unsigned I = DVS - 1 - j;
    logic [bdsf_pkg::DEN_W:0] den;
    logic [bdsf_pkg::DEN_W:0] trx, try_;
    logic                     takex, takey;

    assign den   = {1'b0, dv_ctx_q[j].root, 16'd0};
    assign trx   = {dvx_rem_q[j], dvx_num_q[j][I]};
    assign try_  = {dvy_rem_q[j], dvy_num_q[j][I]};
    assign takex = trx >= den;
    assign takey = try_ >= den;

    always_ff @(posedge clk_i) begin
      if (en) begin
        dvx_rem_q[j+1] <= takex ? 50'(trx - den) : trx[bdsf_pkg::DEN_W-1:0];
        dvy_rem_q[j+1] <= takey ? 50'(try_ - den) : try_[bdsf_pkg::DEN_W-1:0];
        dvx_quo_q[j+1] <= dvx_quo_q[j] | (50'(takex) << I);
        dvy_quo_q[j+1] <= dvy_quo_q[j] | (50'(takey) << I);
        dvx_num_q[j+1] <= dvx_num_q[j];
        dvy_num_q[j+1] <= dvy_num_q[j];
        dv_ctx_q[j+1]  <= dv_ctx_q[j];
      end
    end
  end

  // ---------------------------------------------------------------- stage 7: force
  bdsf_pkg::ctx_t  dc;
  logic [51:0]     spx, spy, drx, dry;
  logic            s7_vld_q;
  bdsf_pkg::res_t  s7_res_q;

  assign dc  = dv_ctx_q[DVS];
  assign spx = dc.coinc ? 52'd0 : ((dc.sdiff ^ dc.sdx) ? (52'd0 - 52'(dvx_quo_q[DVS]))
                                                       : 52'(dvx_quo_q[DVS]));
  assign spy = dc.coinc ? 52'd0 : ((dc.sdiff ^ dc.sdy) ? (52'd0 - 52'(dvy_quo_q[DVS]))
                                                       : 52'(dvy_quo_q[DVS]));
  assign drx = dc.sdvx ? (52'd0 - 52'(dc.mdrx)) : 52'(dc.mdrx);
  assign dry = dc.sdvy ? (52'd0 - 52'(dc.mdry)) : 52'(dc.mdry);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= dv_vld_q[DVS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_res_q.idx   <= dc.idx;
      s7_res_q.coinc <= dc.coinc;
      s7_res_q.fx    <= bdsf_pkg::sat48(spx - drx);
      s7_res_q.fy    <= bdsf_pkg::sat48(spy - dry);
    end
  end

  // ---------------------------------------------------------------- break test
  logic [47:0]     afx, afy, alim;
  logic            q1_vld_q, q2_vld_q, q3_vld_q;
  bdsf_pkg::res_t  q1_res_q, q2_res_q, q3_res_q;
  logic [47:0]     q1_xhh_q, q1_xhl_q, q1_xll_q;
  logic [47:0]     q1_yhh_q, q1_yhl_q, q1_yll_q;
  logic [47:0]     q1_lhh_q, q1_lhl_q, q1_lll_q;
  logic [95:0]     q2_sqx_q, q2_sqy_q, q2_sql_q;
  logic            q3_gt_q;

  assign afx  = s7_res_q.fx[47] ? (48'd0 - s7_res_q.fx) : s7_res_q.fx;
  assign afy  = s7_res_q.fy[47] ? (48'd0 - s7_res_q.fy) : s7_res_q.fy;
  assign alim = {1'b0, limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_vld_q <= 1'b0;
      q2_vld_q <= 1'b0;
      q3_vld_q <= 1'b0;
    end else if (en) begin
      q1_vld_q <= s7_vld_q;
      q2_vld_q <= q1_vld_q;
      q3_vld_q <= q2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_res_q <= s7_res_q;
      q1_xhh_q <= 48'(afx[47:24]) * 48'(afx[47:24]);
      q1_xhl_q <= 48'(afx[47:24]) * 48'(afx[23:0]);
      q1_xll_q <= 48'(afx[23:0]) * 48'(afx[23:0]);
      q1_yhh_q <= 48'(afy[47:24]) * 48'(afy[47:24]);
      q1_yhl_q <= 48'(afy[47:24]) * 48'(afy[23:0]);
      q1_yll_q <= 48'(afy[23:0]) * 48'(afy[23:0]);
      q1_lhh_q <= 48'(alim[47:24]) * 48'(alim[47:24]);
      q1_lhl_q <= 48'(alim[47:24]) * 48'(alim[23:0]);
      q1_lll_q <= 48'(alim[23:0]) * 48'(alim[23:0]);
      q2_res_q <= q1_res_q;
      q2_sqx_q <= bdsf_pkg::sq_combine(q1_xhh_q, q1_xhl_q, q1_xll_q);
      q2_sqy_q <= bdsf_pkg::sq_combine(q1_yhh_q, q1_yhl_q, q1_yll_q);
      q2_sql_q <= bdsf_pkg::sq_combine(q1_lhh_q, q1_lhl_q, q1_lll_q);
      q3_res_q <= q2_res_q;
      q3_gt_q  <= (97'(q2_sqx_q) + 97'(q2_sqy_q)) > 97'(q2_sql_q);
    end
  end

  // ---------------------------------------------------------------- broken flags
  logic            flags_mem [SPRING_COUNT];
  logic            rd_q;
  logic            byp_q;
  logic [IW-1:0]   q2_widx, q3_widx;
  logic [AW-1:0]   q2_addr, q3_addr, raddr, waddr;
  logic            q3_in_range, q3_broken, wr_break, mem_we;
  bdsf_pkg::out_t  new_res;

  assign q2_widx     = IW'(q2_res_q.idx);
  assign q3_widx     = IW'(q3_res_q.idx);
  assign q2_addr     = q2_widx[AW-1:0];
  assign q3_addr     = q3_widx[AW-1:0];
  assign q3_in_range = 17'(q3_res_q.idx) < COUNT_L;
  assign q3_broken   = q3_in_range && (rd_q || byp_q);
  assign wr_break    = en && q3_vld_q && q3_in_range && !q3_broken && q3_gt_q;
  assign mem_we      = !clr_done_q || wr_break;
  assign waddr       = clr_done_q ? q3_addr : clr_cnt_q;

  // While stalled, re-read the entry of the item that sits at the end.
  assign raddr = en ? q2_addr : q3_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flags_mem[waddr] <= clr_done_q;
    end
    rd_q  <= flags_mem[raddr];
    byp_q <= wr_break && (q2_addr == q3_addr);
  end

  always_comb begin
    new_res.force_x         = q3_broken ? '0 : q3_res_q.fx;
    new_res.force_y         = q3_broken ? '0 : q3_res_q.fy;
    new_res.was_active      = !q3_broken;
    new_res.just_broke      = q3_in_range && !q3_broken && q3_gt_q;
    new_res.coincident_ends = !q3_broken && q3_res_q.coinc;
  end

  // ---------------------------------------------------------------- output and skid
  bdsf_pkg::out_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= q3_vld_q;
      end
    end else if (q3_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || out_o.ready) begin
      out_q <= skid_vld_q ? skid_q : new_res;
    end else if (en && q3_vld_q) begin
      skid_q <= new_res;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.force_x         = out_q.force_x;
  assign out_o.force_y         = out_q.force_y;
  assign out_o.was_active      = out_q.was_active;
  assign out_o.just_broke      = out_q.just_broke;
  assign out_o.coincident_ends = out_q.coincident_ends;

  // ---------------------------------------------------------------- assertions
  `BDSF_ASSERT_IMPL(a_broken_gives_zero, out_o.valid && !out_o.was_active,
      out_o.force_x == '0 && out_o.force_y == '0 && !out_o.just_broke,
      "broken spring produced a nonzero result")
  `BDSF_ASSERT_NEXT(a_skid_fill_on_stall, !skid_vld_q && out_vld_q && !out_o.ready && q3_vld_q,
      skid_vld_q, "result beat lost while the receiver stalled")
  `BDSF_ASSERT_IMPL(a_no_break_during_clear, !clr_done_q,
      !wr_break && !q3_vld_q, "flag write or item in flight during clearing pass")
  `BDSF_ASSERT_NEXT(a_break_is_remembered, wr_break,
      rd_q || byp_q || !q3_vld_q || (q3_addr != $past(q3_addr)),
      "freshly broken flag not visible to the next item of the same spring")

endmodule
